/* src/bcr_pkg.sv */
package bcr_pkg;

    localparam int VW    = 16;  // velocity, position and mass fields
    localparam int DW    = 17;  // position and velocity differences
    localparam int PW    = 34;  // one signed 17 x 17 product
    localparam int DOTW  = 35;  // dot product, signed
    localparam int DOTMW = 33;  // dot product magnitude
    localparam int DDW   = 33;  // squared distance
    localparam int CMW   = 16;  // magnitude of one distance component
    localparam int DVDW  = 61;  // divider dividend
    localparam int DVSW  = 33;  // divider divisor
    localparam int QW    = 29;  // divider quotient, one stage per bit
    localparam int MSW   = 17;  // mass sum
    localparam int OPEW  = 17;  // one plus restitution, unsigned Q2.15
    localparam int TW    = 46;  // quotient times (1 + e)
    localparam int NW    = 62;  // impulse numerator
    localparam int XW    = 36;  // rounded numerator over 2^27
    localparam int RSH   = 27;  // impulse scale shift
    localparam int QSH   = 12;  // quotient fraction shift
    localparam int OW    = 31;  // velocity update before clamping

    localparam logic [VW-1:0]   REST_RESET = 16'h8000;
    localparam logic [OPEW-1:0] ONE_Q15    = 17'h08000;

    typedef struct packed {
        logic signed [VW-1:0] vel_a_x;
        logic signed [VW-1:0] vel_a_y;
        logic signed [VW-1:0] vel_b_x;
        logic signed [VW-1:0] vel_b_y;
        logic signed [VW-1:0] pos_a_x;
        logic signed [VW-1:0] pos_a_y;
        logic signed [VW-1:0] pos_b_x;
        logic signed [VW-1:0] pos_b_y;
        logic        [VW-1:0] mass_a;
        logic        [VW-1:0] mass_b;
    } t_req;

    typedef struct packed {
        logic signed [VW-1:0] new_vel_a_x;
        logic signed [VW-1:0] new_vel_a_y;
        logic signed [VW-1:0] new_vel_b_x;
        logic signed [VW-1:0] new_vel_b_y;
        logic                 coincident;
        logic                 saturated;
    } t_rsp;

    // Per-request context that rides alongside the arithmetic
    typedef struct packed {
        logic                 valid;
        logic signed [VW-1:0] vax;
        logic signed [VW-1:0] vay;
        logic signed [VW-1:0] vbx;
        logic signed [VW-1:0] vby;
        logic                 neg_x;
        logic                 neg_y;
        logic                 coin;
        logic                 bypass;
        logic        [VW-1:0] ma;
        logic        [VW-1:0] mb;
        logic        [MSW-1:0] msum;
    } t_side;

endpackage

/* src/ball_collision_with_restitution.sv */
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_stall    i_req (t_req)
// response  out        o_valid / i_stall    o_rsp (t_rsp)
// config    in         i_cfg_we             i_cfg_wdata (restitution, Q1.15)
//
// One request per cycle while the response is not stalled; most of the pipeline is the two
// bit-per-stage dividers (distance squared, then mass sum) in series.
// Reset clears all valid bits and loads restitution with 1.0.
// A stalled response freezes the whole pipeline; o_stall rises in that cycle.
module ball_collision_with_restitution (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    output logic                   o_stall,
    input  bcr_pkg::t_req          i_req,
    output logic                   o_valid,
    input  logic                   i_stall,
    output bcr_pkg::t_rsp          o_rsp,
    input  logic                   i_cfg_we,
    input  logic [bcr_pkg::VW-1:0] i_cfg_wdata
);
    import bcr_pkg::*;

    logic            en;
    logic [VW-1:0]   r_restitution;

    t_side           f_side, d1_side, s_side, d2_side;
    logic [DVDW-1:0] f_dvd_x, f_dvd_y;
    logic [DDW-1:0]  f_dd;
    logic [QW-1:0]   qx, qy, rax, ray, rbx, rby;
    logic [XW-1:0]   xax, xay, xbx, xby;

    assign en      = !(o_valid && i_stall);
    assign o_stall = !en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution <= REST_RESET;
        end else if (i_cfg_we) begin
            r_restitution <= i_cfg_wdata;
        end
    end

    bcr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (i_valid),
        .i_req   (i_req),
        .o_side  (f_side),
        .o_dvd_x (f_dvd_x),
        .o_dvd_y (f_dvd_y),
        .o_dd    (f_dd)
    );

    bcr_div u_div_qx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (f_side), .i_dividend (f_dvd_x), .i_divisor (f_dd),
        .o_side (d1_side), .o_quot (qx)
    );

    bcr_div u_div_qy (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (f_side), .i_dividend (f_dvd_y), .i_divisor (f_dd),
        .o_side (), .o_quot (qy)
    );

    bcr_scale u_scale (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (en),
        .i_side        (d1_side),
        .i_qx          (qx),
        .i_qy          (qy),
        .i_restitution (r_restitution),
        .o_side        (s_side),
        .o_xax         (xax),
        .o_xay         (xay),
        .o_xbx         (xbx),
        .o_xby         (xby)
    );

    bcr_div u_div_ax (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (s_side), .i_dividend (DVDW'(xax)), .i_divisor (DVSW'(s_side.msum)),
        .o_side (d2_side), .o_quot (rax)
    );

    bcr_div u_div_ay (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (s_side), .i_dividend (DVDW'(xay)), .i_divisor (DVSW'(s_side.msum)),
        .o_side (), .o_quot (ray)
    );

    bcr_div u_div_bx (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (s_side), .i_dividend (DVDW'(xbx)), .i_divisor (DVSW'(s_side.msum)),
        .o_side (), .o_quot (rbx)
    );

    bcr_div u_div_by (
        .i_clk (i_clk), .i_rst_n (i_rst_n), .i_en (en),
        .i_side (s_side), .i_dividend (DVDW'(xby)), .i_divisor (DVSW'(s_side.msum)),
        .o_side (), .o_quot (rby)
    );

    bcr_sat u_sat (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_side  (d2_side),
        .i_rax   (rax),
        .i_ray   (ray),
        .i_rbx   (rbx),
        .i_rby   (rby),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

/* src/bcr_div.sv */
module bcr_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  bcr_pkg::t_side              i_side,
    input  logic [bcr_pkg::DVDW-1:0]    i_dividend,
    input  logic [bcr_pkg::DVSW-1:0]    i_divisor,
    output bcr_pkg::t_side              o_side,
    output logic [bcr_pkg::QW-1:0]      o_quot
);
    import bcr_pkg::*;

    // Restoring divider, one quotient bit per stage; quotient is known to fit QW bits
    t_side            r_side [QW];
    logic [DVSW-1:0]  r_rem  [QW];
    logic [DVSW-1:0]  r_div  [QW];
    logic [QW-1:0]    r_low  [QW];
    logic [QW-1:0]    r_quo  [QW];

    t_side            n_side [QW];
    logic [DVSW-1:0]  n_rem  [QW];
    logic [DVSW-1:0]  n_div  [QW];
    logic [QW-1:0]    n_low  [QW];
    logic [QW-1:0]    n_quo  [QW];

    t_side            p_side [QW];
    logic [DVSW-1:0]  p_rem  [QW];
    logic [DVSW-1:0]  p_div  [QW];
    logic [QW-1:0]    p_low  [QW];
    logic [QW-1:0]    p_quo  [QW];
    logic [DVSW:0]    trial  [QW];

    always_comb begin
        for (int k = 0; k < QW; k++) begin
            if (k == 0) begin
                p_side[k] = i_side;
                p_rem[k]  = DVSW'(i_dividend[DVDW-1:QW]);
                p_div[k]  = i_divisor;
                p_low[k]  = i_dividend[QW-1:0];
                p_quo[k]  = '0;
            end else begin
                p_side[k] = r_side[k-1];
                p_rem[k]  = r_rem[k-1];
                p_div[k]  = r_div[k-1];
                p_low[k]  = r_low[k-1];
                p_quo[k]  = r_quo[k-1];
            end
            trial[k]  = {p_rem[k], p_low[k][QW-1]};
            n_side[k] = p_side[k];
            n_div[k]  = p_div[k];
            n_low[k]  = {p_low[k][QW-2:0], 1'b0};
            if (trial[k] >= {1'b0, p_div[k]}) begin
                n_rem[k] = DVSW'(trial[k] - {1'b0, p_div[k]});
                n_quo[k] = {p_quo[k][QW-2:0], 1'b1};
            end else begin
                n_rem[k] = DVSW'(trial[k]);
                n_quo[k] = {p_quo[k][QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k < QW; k++) begin
            if (!i_rst_n) begin
                r_side[k].valid <= 1'b0;
            end else if (i_en) begin
                r_side[k] <= n_side[k];
                r_rem[k]  <= n_rem[k];
                r_div[k]  <= n_div[k];
                r_low[k]  <= n_low[k];
                r_quo[k]  <= n_quo[k];
            end
        end
    end

    assign o_side = r_side[QW-1];
    assign o_quot = r_quo[QW-1];

endmodule

/* src/bcr_front.sv */
module bcr_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_valid,
    input  bcr_pkg::t_req               i_req,
    output bcr_pkg::t_side              o_side,
    output logic [bcr_pkg::DVDW-1:0]    o_dvd_x,
    output logic [bcr_pkg::DVDW-1:0]    o_dvd_y,
    output logic [bcr_pkg::DDW-1:0]     o_dd
);
    import bcr_pkg::*;

    // Stage 1: differences
    logic                 r1_valid;
    t_req                 r1_req;
    logic signed [DW-1:0] r1_dx, r1_dy, r1_dvx, r1_dvy;
    logic signed [DW-1:0] n1_dx, n1_dy, n1_dvx, n1_dvy;

    // Stage 2: products
    logic                 r2_valid;
    t_req                 r2_req;
    logic signed [PW-1:0] r2_pdx, r2_pdy;
    logic [31:0]          r2_sqx, r2_sqy;
    logic [CMW-1:0]       r2_cmx, r2_cmy;
    logic                 r2_cnx, r2_cny;
    logic signed [PW-1:0] n2_pdx, n2_pdy, n2_sqx, n2_sqy;
    logic signed [DW-1:0] n2_ax, n2_ay;

    // Stage 3: sums
    logic                 r3_valid;
    t_req                 r3_req;
    logic [DOTMW-1:0]     r3_dotm;
    logic                 r3_dotn;
    logic [DDW-1:0]       r3_dd;
    logic [CMW-1:0]       r3_cmx, r3_cmy;
    logic                 r3_cnx, r3_cny;
    logic signed [DOTW-1:0] n3_dot;
    logic signed [DOTW-1:0] n3_dotabs;

    // Stage 4: dividends
    t_side                r4_side, n4_side;
    logic [DVDW-1:0]      r4_dvd_x, r4_dvd_y;
    logic [DDW-1:0]       r4_dd;
    logic [DVDW-QSH-1:0]  n4_px, n4_py;

    always_comb begin
        n1_dx  = {i_req.pos_a_x[VW-1], i_req.pos_a_x} - {i_req.pos_b_x[VW-1], i_req.pos_b_x};
        n1_dy  = {i_req.pos_a_y[VW-1], i_req.pos_a_y} - {i_req.pos_b_y[VW-1], i_req.pos_b_y};
        n1_dvx = {i_req.vel_a_x[VW-1], i_req.vel_a_x} - {i_req.vel_b_x[VW-1], i_req.vel_b_x};
        n1_dvy = {i_req.vel_a_y[VW-1], i_req.vel_a_y} - {i_req.vel_b_y[VW-1], i_req.vel_b_y};

        n2_pdx = r1_dvx * r1_dx;
        n2_pdy = r1_dvy * r1_dy;
        n2_sqx = r1_dx * r1_dx;
        n2_sqy = r1_dy * r1_dy;
        n2_ax  = r1_dx[DW-1] ? -r1_dx : r1_dx;
        n2_ay  = r1_dy[DW-1] ? -r1_dy : r1_dy;

        n3_dot    = DOTW'(r2_pdx) + DOTW'(r2_pdy);
        n3_dotabs = n3_dot[DOTW-1] ? -n3_dot : n3_dot;

        n4_px = (DVDW-QSH)'(r3_dotm) * (DVDW-QSH)'(r3_cmx);
        n4_py = (DVDW-QSH)'(r3_dotm) * (DVDW-QSH)'(r3_cmy);

        n4_side.valid  = r3_valid;
        n4_side.vax    = r3_req.vel_a_x;
        n4_side.vay    = r3_req.vel_a_y;
        n4_side.vbx    = r3_req.vel_b_x;
        n4_side.vby    = r3_req.vel_b_y;
        n4_side.neg_x  = r3_dotn ^ r3_cnx;
        n4_side.neg_y  = r3_dotn ^ r3_cny;
        n4_side.coin   = (r3_dd == '0);
        n4_side.ma     = r3_req.mass_a;
        n4_side.mb     = r3_req.mass_b;
        n4_side.msum   = {1'b0, r3_req.mass_a} + {1'b0, r3_req.mass_b};
        n4_side.bypass = n4_side.coin || (n4_side.msum == '0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid      <= 1'b0;
            r2_valid      <= 1'b0;
            r3_valid      <= 1'b0;
            r4_side.valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r1_req   <= i_req;
            r1_dx    <= n1_dx;
            r1_dy    <= n1_dy;
            r1_dvx   <= n1_dvx;
            r1_dvy   <= n1_dvy;

            r2_valid <= r1_valid;
            r2_req   <= r1_req;
            r2_pdx   <= n2_pdx;
            r2_pdy   <= n2_pdy;
            r2_sqx   <= n2_sqx[31:0];
            r2_sqy   <= n2_sqy[31:0];
            r2_cmx   <= n2_ax[CMW-1:0];
            r2_cmy   <= n2_ay[CMW-1:0];
            r2_cnx   <= r1_dx[DW-1];
            r2_cny   <= r1_dy[DW-1];

            r3_valid <= r2_valid;
            r3_req   <= r2_req;
            r3_dotm  <= n3_dotabs[DOTMW-1:0];
            r3_dotn  <= n3_dot[DOTW-1];
            r3_dd    <= {1'b0, r2_sqx} + {1'b0, r2_sqy};
            r3_cmx   <= r2_cmx;
            r3_cmy   <= r2_cmy;
            r3_cnx   <= r2_cnx;
            r3_cny   <= r2_cny;

            r4_side  <= n4_side;
            r4_dvd_x <= {n4_px, {QSH{1'b0}}};
            r4_dvd_y <= {n4_py, {QSH{1'b0}}};
            r4_dd    <= r3_dd;
        end
    end

    assign o_side  = r4_side;
    assign o_dvd_x = r4_dvd_x;
    assign o_dvd_y = r4_dvd_y;
    assign o_dd    = r4_dd;

endmodule

/* src/bcr_scale.sv */
module bcr_scale (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  bcr_pkg::t_side            i_side,
    input  logic [bcr_pkg::QW-1:0]    i_qx,
    input  logic [bcr_pkg::QW-1:0]    i_qy,
    input  logic [bcr_pkg::VW-1:0]    i_restitution,
    output bcr_pkg::t_side            o_side,
    output logic [bcr_pkg::XW-1:0]    o_xax,
    output logic [bcr_pkg::XW-1:0]    o_xay,
    output logic [bcr_pkg::XW-1:0]    o_xbx,
    output logic [bcr_pkg::XW-1:0]    o_xby
);
    import bcr_pkg::*;

    logic [OPEW-1:0] ope;

    t_side          r5_side;
    logic [TW-1:0]  r5_tx, r5_ty;

    t_side          r6_side;
    logic [NW-1:0]  r6_nax, r6_nay, r6_nbx, r6_nby;

    t_side          r7_side;
    logic [XW-1:0]  r7_xax, r7_xay, r7_xbx, r7_xby;

    logic [NW:0]    n7_half;
    logic [NW:0]    n7_sax, n7_say, n7_sbx, n7_sby;

    always_comb begin
        ope     = ONE_Q15 + {1'b0, i_restitution};
        // Add half the denominator, then drop 2^27; the division by the mass sum follows
        n7_half = (NW+1)'(r6_side.msum) << (RSH - 1);
        n7_sax  = {1'b0, r6_nax} + n7_half;
        n7_say  = {1'b0, r6_nay} + n7_half;
        n7_sbx  = {1'b0, r6_nbx} + n7_half;
        n7_sby  = {1'b0, r6_nby} + n7_half;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_side.valid <= 1'b0;
            r6_side.valid <= 1'b0;
            r7_side.valid <= 1'b0;
        end else if (i_en) begin
            r5_side <= i_side;
            r5_tx   <= TW'(i_qx) * TW'(ope);
            r5_ty   <= TW'(i_qy) * TW'(ope);

            r6_side <= r5_side;
            r6_nax  <= NW'(r5_tx) * NW'(r5_side.mb);
            r6_nay  <= NW'(r5_ty) * NW'(r5_side.mb);
            r6_nbx  <= NW'(r5_tx) * NW'(r5_side.ma);
            r6_nby  <= NW'(r5_ty) * NW'(r5_side.ma);

            r7_side <= r6_side;
            r7_xax  <= n7_sax[NW:RSH];
            r7_xay  <= n7_say[NW:RSH];
            r7_xbx  <= n7_sbx[NW:RSH];
            r7_xby  <= n7_sby[NW:RSH];
        end
    end

    assign o_side = r7_side;
    assign o_xax  = r7_xax;
    assign o_xay  = r7_xay;
    assign o_xbx  = r7_xbx;
    assign o_xby  = r7_xby;

endmodule

/* src/bcr_sat.sv */
module bcr_sat (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_en,
    input  bcr_pkg::t_side          i_side,
    input  logic [bcr_pkg::QW-1:0]  i_rax,
    input  logic [bcr_pkg::QW-1:0]  i_ray,
    input  logic [bcr_pkg::QW-1:0]  i_rbx,
    input  logic [bcr_pkg::QW-1:0]  i_rby,
    output logic                    o_valid,
    output bcr_pkg::t_rsp           o_rsp
);
    import bcr_pkg::*;

    logic                 r_valid;
    t_rsp                 r_rsp;
    t_rsp                 n_rsp;
    logic signed [OW-1:0] sum_ax, sum_ay, sum_bx, sum_by;
    logic                 c_ax, c_ay, c_bx, c_by;

    function automatic logic signed [OW-1:0] upd(input logic signed [VW-1:0] v,
                                                 input logic [QW-1:0] r,
                                                 input logic neg, input logic sub);
        logic signed [OW-1:0] imp;
        imp = neg ? -$signed({2'b00, r}) : $signed({2'b00, r});
        return sub ? (OW'(v) - imp) : (OW'(v) + imp);
    endfunction

    function automatic logic signed [VW-1:0] clamp(input logic signed [OW-1:0] s);
        if (s > OW'(32767)) begin
            return 16'sh7fff;
        end else if (s < -OW'(32768)) begin
            return -16'sh8000;
        end
        return s[VW-1:0];
    endfunction

    always_comb begin
        sum_ax = upd(i_side.vax, i_rax, i_side.neg_x, 1'b1);
        sum_ay = upd(i_side.vay, i_ray, i_side.neg_y, 1'b1);
        sum_bx = upd(i_side.vbx, i_rbx, i_side.neg_x, 1'b0);
        sum_by = upd(i_side.vby, i_rby, i_side.neg_y, 1'b0);
        c_ax   = (sum_ax != OW'(clamp(sum_ax)));
        c_ay   = (sum_ay != OW'(clamp(sum_ay)));
        c_bx   = (sum_bx != OW'(clamp(sum_bx)));
        c_by   = (sum_by != OW'(clamp(sum_by)));

        n_rsp.coincident = i_side.coin;
        if (i_side.bypass) begin
            n_rsp.new_vel_a_x = i_side.vax;
            n_rsp.new_vel_a_y = i_side.vay;
            n_rsp.new_vel_b_x = i_side.vbx;
            n_rsp.new_vel_b_y = i_side.vby;
            n_rsp.saturated   = 1'b0;
        end else begin
            n_rsp.new_vel_a_x = clamp(sum_ax);
            n_rsp.new_vel_a_y = clamp(sum_ay);
            n_rsp.new_vel_b_x = clamp(sum_bx);
            n_rsp.new_vel_b_y = clamp(sum_by);
            n_rsp.saturated   = c_ax | c_ay | c_bx | c_by;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_side.valid;
            r_rsp   <= n_rsp;
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

/* src/bcr_check.sv */
module bcr_check (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   o_stall,
    input logic                   o_valid,
    input logic                   i_stall,
    input bcr_pkg::t_rsp          o_rsp
);

    // Hold a stalled response
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_rsp))
        else $error("stalled response changed");

    // Push back only while a response is waiting
    a_stall_cause: assert property (@(posedge i_clk)
        o_stall |-> o_valid && i_stall)
        else $error("request stalled without a waiting response");

    a_coin_nosat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_rsp.coincident |-> !o_rsp.saturated)
        else $error("coincident response flagged as clamped");

    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("response valid right after reset");

endmodule

bind ball_collision_with_restitution bcr_check u_bcr_check (.*);

/* dv/tb_ball_collision_with_restitution.sv */
`timescale 1ns / 1ps

module tb_ball_collision_with_restitution;
    import bcr_pkg::*;

    localparam int LATENCY = 2 * QW + 8;

    typedef struct {
        t_req req;
        bit   typed;
        t_rsp rsp;
    } t_row;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    t_req              i_req;
    logic              o_valid;
    logic              i_stall;
    t_rsp              o_rsp;
    logic              i_cfg_we;
    logic [VW-1:0]     i_cfg_wdata;

    logic [VW-1:0]     rest_q15;
    t_rsp              pending_rsp[$];
    int                n_fail;
    int                n_sent;
    int                n_rcvd;
    int                idle_pct;
    int                stall_pct;
    bit                hold_go;
    int                hold_left;

    ball_collision_with_restitution u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_req      (i_req),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_rsp      (o_rsp),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_wdata(i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint signed impulse_part(longint unsigned dot_mag, bit dot_neg,
                                                   longint signed c, longint unsigned dd,
                                                   longint unsigned ope, longint unsigned m,
                                                   longint unsigned msum);
        longint unsigned c_mag;
        longint unsigned q;
        longint unsigned num;
        longint unsigned den;
        longint unsigned r;
        c_mag = (c < 0) ? longint'(-c) : longint'(c);
        q   = ((dot_mag * c_mag) << QSH) / dd;
        num = q * ope * m;
        den = msum << RSH;
        r   = (num + (den >> 1)) / den;
        return (dot_neg != (c < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function automatic logic [VW-1:0] clamp16(longint signed v, inout bit sat);
        if (v > 32767) begin
            sat = 1'b1;
            v   = 32767;
        end
        if (v < -32768) begin
            sat = 1'b1;
            v   = -32768;
        end
        return v[VW-1:0];
    endfunction

    function automatic t_rsp collide(t_req r, logic [VW-1:0] e);
        longint signed   vax, vay, vbx, vby, dx, dy, dot, nax, nay, nbx, nby;
        longint unsigned ma, mb, msum, dd, dot_mag, ope;
        bit              sat;
        t_rsp            o;
        vax = longint'(r.vel_a_x); vay = longint'(r.vel_a_y);
        vbx = longint'(r.vel_b_x); vby = longint'(r.vel_b_y);
        dx  = longint'(r.pos_a_x) - longint'(r.pos_b_x);
        dy  = longint'(r.pos_a_y) - longint'(r.pos_b_y);
        ma  = 64'(r.mass_a);
        mb  = 64'(r.mass_b);
        msum = ma + mb;
        dd  = longint'(dx * dx + dy * dy);
        sat = 1'b0;
        nax = vax; nay = vay; nbx = vbx; nby = vby;
        if (dd != 0 && msum != 0) begin
            dot     = (vax - vbx) * dx + (vay - vby) * dy;
            dot_mag = (dot < 0) ? longint'(-dot) : longint'(dot);
            ope     = 32768 + longint'(e);
            nax = vax - impulse_part(dot_mag, dot < 0, dx, dd, ope, mb, msum);
            nay = vay - impulse_part(dot_mag, dot < 0, dy, dd, ope, mb, msum);
            nbx = vbx + impulse_part(dot_mag, dot < 0, dx, dd, ope, ma, msum);
            nby = vby + impulse_part(dot_mag, dot < 0, dy, dd, ope, ma, msum);
        end
        o.new_vel_a_x = clamp16(nax, sat);
        o.new_vel_a_y = clamp16(nay, sat);
        o.new_vel_b_x = clamp16(nbx, sat);
        o.new_vel_b_y = clamp16(nby, sat);
        o.coincident  = (dd == 0);
        o.saturated   = sat;
        return o;
    endfunction

    function automatic t_req mk_req(int vax, int vay, int vbx, int vby, int pax, int pay,
                                    int pbx, int pby, int ma, int mb);
        t_req r;
        r.vel_a_x = VW'(vax); r.vel_a_y = VW'(vay);
        r.vel_b_x = VW'(vbx); r.vel_b_y = VW'(vby);
        r.pos_a_x = VW'(pax); r.pos_a_y = VW'(pay);
        r.pos_b_x = VW'(pbx); r.pos_b_y = VW'(pby);
        r.mass_a  = VW'(ma);  r.mass_b  = VW'(mb);
        return r;
    endfunction

    function automatic t_rsp mk_rsp(int ax, int ay, int bx, int by, bit coin, bit sat);
        t_rsp o;
        o.new_vel_a_x = VW'(ax); o.new_vel_a_y = VW'(ay);
        o.new_vel_b_x = VW'(bx); o.new_vel_b_y = VW'(by);
        o.coincident  = coin;
        o.saturated   = sat;
        return o;
    endfunction

    function automatic t_req rand_req();
        t_req r;
        int   kind;
        r    = {$urandom, $urandom, $urandom, $urandom, $urandom};
        kind = $urandom_range(0, 9);
        // mostly nearby centres and some moderate speed components, like real contacts
        if (kind < 6) begin
            r.pos_b_x = r.pos_a_x + 16'($signed($urandom_range(0, 1023)) - 512);
            r.pos_b_y = r.pos_a_y + 16'($signed($urandom_range(0, 1023)) - 512);
            r.vel_a_x = 16'($signed($urandom_range(0, 8191)) - 4096);
            r.vel_b_y = 16'($signed($urandom_range(0, 8191)) - 4096);
        end else if (kind == 6) begin
            r.pos_b_x = r.pos_a_x;
            r.pos_b_y = r.pos_a_y;
        end
        if (kind == 7) begin
            r.mass_a = VW'($urandom_range(1, 1023));
        end
        if (r.mass_a == 0) r.mass_a = 1;
        if (r.mass_b == 0) r.mass_b = 16'hFFFF;
        return r;
    endfunction

    task automatic send(t_req r, bit typed, t_rsp typed_rsp);
        while ($urandom_range(0, 99) < idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_req   <= r;
        do @(posedge i_clk); while (o_stall);
        pending_rsp.push_back(typed ? typed_rsp : collide(r, rest_q15));
        n_sent++;
    endtask

    task automatic drain_idle();
        int guard;
        i_valid <= 1'b0;
        guard = 0;
        while (pending_rsp.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (LATENCY + 4) @(posedge i_clk);
    endtask

    task automatic write_rest(logic [VW-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        rest_q15    = v;
        i_cfg_we    <= 1'b0;
    endtask

    // response side: random stall plus a counted long hold-off
    always @(posedge i_clk) begin
        if (hold_go && hold_left == 0) begin
            hold_left = 3 * LATENCY;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_stall <= 1'b1;
        end else begin
            i_stall <= ($urandom_range(0, 99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        t_rsp want;
        if (i_rst_n && o_valid && !i_stall) begin
            n_rcvd++;
            if (pending_rsp.size() == 0) begin
                $error("unexpected response");
                n_fail++;
            end else begin
                want = pending_rsp.pop_front();
                if (o_rsp.new_vel_a_x !== want.new_vel_a_x) begin
                    $error("new_vel_a_x exp %0d got %0d", want.new_vel_a_x, o_rsp.new_vel_a_x);
                    n_fail++;
                end
                if (o_rsp.new_vel_a_y !== want.new_vel_a_y) begin
                    $error("new_vel_a_y exp %0d got %0d", want.new_vel_a_y, o_rsp.new_vel_a_y);
                    n_fail++;
                end
                if (o_rsp.new_vel_b_x !== want.new_vel_b_x) begin
                    $error("new_vel_b_x exp %0d got %0d", want.new_vel_b_x, o_rsp.new_vel_b_x);
                    n_fail++;
                end
                if (o_rsp.new_vel_b_y !== want.new_vel_b_y) begin
                    $error("new_vel_b_y exp %0d got %0d", want.new_vel_b_y, o_rsp.new_vel_b_y);
                    n_fail++;
                end
                if (o_rsp.coincident !== want.coincident) begin
                    $error("coincident exp %0d got %0d", want.coincident, o_rsp.coincident);
                    n_fail++;
                end
                if (o_rsp.saturated !== want.saturated) begin
                    $error("saturated exp %0d got %0d", want.saturated, o_rsp.saturated);
                    n_fail++;
                end
            end
        end
    end

    initial begin
        t_row            rows[$];
        t_rsp            none;
        logic [VW-1:0]   rest_seq[5];
        int              idle_seq[5];
        int              stall_seq[5];
        n_fail = 0; n_sent = 0; n_rcvd = 0;
        idle_pct = 0; stall_pct = 0;
        hold_go = 1'b0; hold_left = 0;
        none = '0;
        rest_q15    = REST_RESET;
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_req       = '0;
        i_stall     = 1'b0;
        i_cfg_we    = 1'b0;
        i_cfg_wdata = '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // coincident centres pass velocities through
        rows.push_back('{mk_req(32767, -32768, -32768, 32767, 0, 0, 0, 0, 1, 1), 1,
                         mk_rsp(32767, -32768, -32768, 32767, 1, 0)});
        rows.push_back('{mk_req(-32768, 32767, 32767, -32768, 32767, -32768, 32767, -32768,
                                65535, 65535), 1,
                         mk_rsp(-32768, 32767, 32767, -32768, 1, 0)});
        // equal velocities: no relative motion, no impulse
        rows.push_back('{mk_req(4660, -300, 4660, -300, 100, 50, -20, 7, 300, 9000), 1,
                         mk_rsp(4660, -300, 4660, -300, 0, 0)});
        // equal masses, head-on, elastic: velocities swap
        rows.push_back('{mk_req(256, 0, -256, 0, 16, 0, 0, 0, 256, 256), 1,
                         mk_rsp(-256, 0, 256, 0, 0, 0)});
        rows.push_back('{mk_req(32767, 32767, -32768, -32768, 32767, 32767, -32768, -32768,
                                65535, 65535), 0, none});
        rows.push_back('{mk_req(32767, -32768, -32768, 32767, 1, 0, 0, 0, 65535, 65535),
                         0, none});
        rows.push_back('{mk_req(-32768, 0, 32767, 0, 0, 1, 0, 0, 1, 65535), 0, none});
        rows.push_back('{mk_req(1000, -2000, -3000, 500, -32768, 32767, 32767, -32768,
                                65535, 1), 0, none});
        rows.push_back('{mk_req(-512, 700, 512, -700, 40, 30, 0, 0, 1, 1), 0, none});
        rows.push_back('{mk_req(1, 1, 0, 0, 1, 1, 0, 0, 65535, 1), 0, none});
        rows.push_back('{mk_req(32767, 32767, -32768, -32768, 3, -5, 0, 0, 1, 65535),
                         0, none});
        rows.push_back('{mk_req(-1, -1, -1, -1, -1, -1, -1, -1, 65535, 65535), 1,
                         mk_rsp(-1, -1, -1, -1, 1, 0)});

        // table rows are replayed in phase 3, which must stay elastic
        rest_seq  = '{16'h8000, 16'h0000, 16'h0000, 16'h8000, 16'h4000};
        idle_seq  = '{0, 74, 0, 9, 0};
        stall_seq = '{0, 0, 74, 9, 0};
        rest_seq[2] = VW'($urandom_range(1, 32767));

        for (int ph = 0; ph < 5; ph++) begin
            idle_pct  = idle_seq[ph];
            stall_pct = stall_seq[ph];
            if (ph != 0) write_rest(rest_seq[ph]);
            if (ph == 0 || ph == 3) begin
                foreach (rows[k]) send(rows[k].req, rows[k].typed, rows[k].rsp);
            end
            for (int n = 0; n < 105; n++) begin
                if (ph == 4 && n == 10) hold_go <= 1'b1;
                // pause until the pipe empties, then resume
                if (ph == 3 && n == 50) drain_idle();
                send(rand_req(), 0, none);
            end
            drain_idle();
        end
        write_rest(16'h8000);
        repeat (LATENCY + 4) @(posedge i_clk);

        $display("sent %0d collision requests, received %0d responses", n_sent, n_rcvd);
        $display("restitution 0, 0.5, random and 1.0 under idle, stall and hold-off");
        if (n_fail == 0 && pending_rsp.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end
endmodule
